// ===== hw/rtl/modbus_rtu_frame_checker_defines.svh =====
// Assertion macros shared by the frame checker RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef MODBUS_RTU_FRAME_CHECKER_DEFINES_SVH
`define MODBUS_RTU_FRAME_CHECKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRTU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mrtu_pkg.sv =====
`timescale 1ns / 1ps
package mrtu_pkg;

    localparam logic        CMD_BYTE = 1'b0;
    localparam logic        CMD_TICK = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int          MIN_LEN  = 6;
    localparam logic [7:0]  IDLE_MAX = 8'hFF;

    localparam int          CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_FUNCTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOUVER_FUNCTION = 3'd3;

    localparam logic [7:0]  RST_DEVICE_ADDRESS  = 8'h10;
    localparam logic [7:0]  RST_SILENCE_TICKS   = 8'd20;
    localparam logic [7:0]  RST_SENSOR_FUNCTION = 8'h20;
    localparam logic [7:0]  RST_LOUVER_FUNCTION = 8'h21;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_CRC_ERROR = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_OTHER_ADDR = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RK_NONE    = 2'd0,
        RK_SENSOR  = 2'd1,
        RK_LOUVER  = 2'd2,
        RK_INVALID = 2'd3
    } t_reply_kind;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] silence_ticks;
        logic [7:0] sensor_function;
        logic [7:0] louver_function;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [7:0]  func_code;
        t_reply_kind kind;
        logic [8:0]  length;
    } t_result;

    // Modbus CRC-16, one byte, reflected polynomial, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/modbus_rtu_frame_checker.sv =====
`timescale 1ns / 1ps
// Modbus RTU request frame checker. Each input word is a received byte or one timer tick,
// and a new word can be taken every clock cycle while the input is not stalled; the word
// that closes a frame goes through the input register, then the combinational CRC byte
// update and frame check, into the result register. A full result register stalls the
// input side only while the result is not taken. Configuration writes take effect for
// words processed from the next cycle on.
module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_frame_status,
    output logic [7:0]                    o_func_code,
    output logic [1:0]                    o_reply_kind,
    output logic [8:0]                    o_frame_length,
    input  logic                          i_cfg_wr_en,
    input  logic [mrtu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_wr_data
);
    import mrtu_pkg::*;

    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    logic       close;
    t_cfg       cfg;
    t_result    result;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    mrtu_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    mrtu_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_command   (r_in_command),
        .i_data_byte (r_in_byte),
        .i_cfg       (cfg),
        .o_close     (close),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= step && close;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_command <= i_command;
            r_in_byte    <= i_data_byte;
        end
        if (step && close) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_status  = r_out.status;
    assign o_func_code     = r_out.func_code;
    assign o_reply_kind    = r_out.kind;
    assign o_frame_length  = r_out.length;

endmodule

// ===== hw/rtl/mrtu_cfg.sv =====
`timescale 1ns / 1ps
module mrtu_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mrtu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_wr_data,
    output mrtu_pkg::t_cfg                o_cfg
);
    import mrtu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DEVICE_ADDRESS:  n_cfg.device_address  = i_cfg_wr_data;
                REG_SILENCE_TICKS:   n_cfg.silence_ticks   = i_cfg_wr_data;
                REG_SENSOR_FUNCTION: n_cfg.sensor_function = i_cfg_wr_data;
                REG_LOUVER_FUNCTION: n_cfg.louver_function = i_cfg_wr_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address  <= RST_DEVICE_ADDRESS;
            r_cfg.silence_ticks   <= RST_SILENCE_TICKS;
            r_cfg.sensor_function <= RST_SENSOR_FUNCTION;
            r_cfg.louver_function <= RST_LOUVER_FUNCTION;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/mrtu_frame.sv =====
`timescale 1ns / 1ps
`include "modbus_rtu_frame_checker_defines.svh"
module mrtu_frame #(
    parameter int MAX_FRAME = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_command,
    input  logic [7:0]       i_data_byte,
    input  mrtu_pkg::t_cfg   i_cfg,
    output logic             o_close,
    output mrtu_pkg::t_result o_result
);
    import mrtu_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);
    localparam logic [CW-1:0] MIN_CNT = CW'(MIN_LEN);

    logic [15:0]   r_crc,   n_crc;
    logic [15:0]   r_held,  n_held;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_idle,  n_idle;
    logic          r_in_frame, n_in_frame;
    logic [7:0]    r_addr,  n_addr;
    logic [7:0]    r_func,  n_func;

    logic [15:0]   crc_b;
    logic [15:0]   held_b;
    logic [CW-1:0] cnt_b;
    logic [7:0]    addr_b;
    logic [7:0]    func_b;
    logic [7:0]    idle_inc;
    logic [15:0]   received;
    logic          close;

    always_comb begin
        crc_b  = r_in_frame ? r_crc   : CRC_INIT;
        held_b = r_in_frame ? r_held  : 16'h0000;
        cnt_b  = r_in_frame ? r_count : '0;
        addr_b = r_in_frame ? r_addr  : 8'h00;
        func_b = r_in_frame ? r_func  : 8'h00;
        idle_inc = (r_idle != IDLE_MAX) ? r_idle + 8'd1 : r_idle;

        n_crc      = r_crc;
        n_held     = r_held;
        n_count    = r_count;
        n_idle     = r_idle;
        n_in_frame = r_in_frame;
        n_addr     = r_addr;
        n_func     = r_func;
        close      = 1'b0;

        if (i_step) begin
            if (i_command == CMD_TICK) begin
                if (r_in_frame) begin
                    n_idle = idle_inc;
                    close  = (idle_inc >= i_cfg.silence_ticks);
                end
            end else begin
                n_in_frame = 1'b1;
                n_crc      = (cnt_b >= CW'(2)) ? crc_feed(crc_b, held_b[15:8]) : crc_b;
                n_held     = {held_b[7:0], i_data_byte};
                n_addr     = (cnt_b == CW'(0)) ? i_data_byte : addr_b;
                n_func     = (cnt_b == CW'(1)) ? i_data_byte : func_b;
                n_count    = cnt_b + CW'(1);
                n_idle     = 8'h00;
                close      = (n_count == MAX_CNT);
            end
        end

        if (close) begin
            n_in_frame = 1'b0;
            n_idle     = 8'h00;
        end

        // The check bytes arrive low byte first.
        received = {n_held[7:0], n_held[15:8]};

        o_result.func_code = n_func;
        o_result.length    = 9'(n_count);
        o_result.kind      = RK_NONE;
        if (n_count <= MIN_CNT) begin
            o_result.status = ST_TOO_SHORT;
        end else if (n_crc != received) begin
            o_result.status = ST_CRC_ERROR;
        end else if (n_addr != i_cfg.device_address) begin
            o_result.status = ST_OTHER_ADDR;
        end else begin
            o_result.status = ST_ACCEPTED;
            if (n_func == i_cfg.sensor_function) begin
                o_result.kind = RK_SENSOR;
            end else if (n_func == i_cfg.louver_function) begin
                o_result.kind = RK_LOUVER;
            end else begin
                o_result.kind = RK_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_idle     <= 8'h00;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_held     <= 16'h0000;
            r_addr     <= 8'h00;
            r_func     <= 8'h00;
        end else begin
            r_in_frame <= n_in_frame;
            r_idle     <= n_idle;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_held     <= n_held;
            r_addr     <= n_addr;
            r_func     <= n_func;
        end
    end

    assign o_close = close;

    `MRTU_ASSERT_SAME(a_idle_only_in_frame, !r_in_frame, r_idle == 8'h00,
        "idle counter running with no frame open")
    `MRTU_ASSERT_SAME(a_open_frame_has_bytes, r_in_frame, r_count != '0,
        "open frame holds no bytes")
    `MRTU_ASSERT_NEXT(a_byte_opens_or_closes, i_step && i_command == CMD_BYTE && !close,
        r_in_frame, "byte that did not close a frame left it shut")

endmodule

// ===== test/tb_modbus_rtu_frame_checker.sv =====
`timescale 1ns / 1ps
module tb_modbus_rtu_frame_checker;
    import mrtu_pkg::*;

    localparam int FRAME_CAP    = 256;
    localparam int RANDOM_WORDS = 180;
    localparam int PHASE_WORDS  = 60;
    localparam int HOLD_CYCLES  = 60;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } t_rx_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_command = CMD_TICK;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_stall = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_DEVICE_ADDRESS;
    logic [7:0]           i_cfg_wr_data = 8'h00;
    logic                 o_stall;
    logic                 o_valid;
    logic [1:0]           o_frame_status;
    logic [7:0]           o_func_code;
    logic [1:0]           o_reply_kind;
    logic [8:0]           o_frame_length;

    t_rx_word rx_word_q[$];
    t_result  report_q[$];
    int       mismatches = 0;
    int       words_queued = 0;
    int       hold_asked = 0;
    int       hold_seen = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    bit       calm = 1'b0;
    logic     in_fire = 1'b0;

    logic [7:0] stim_addr = RST_DEVICE_ADDRESS;
    logic [7:0] stim_sil = RST_SILENCE_TICKS;
    logic [7:0] stim_sens = RST_SENSOR_FUNCTION;
    logic [7:0] stim_louv = RST_LOUVER_FUNCTION;

    // Shadow of the frame checker: configuration and the state of the open frame.
    t_cfg        shadow_cfg;
    logic [15:0] crc_run;
    logic [15:0] tail_bytes;
    logic [8:0]  frame_bytes;
    logic [7:0]  quiet_ticks;
    logic        frame_open;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;

    modbus_rtu_frame_checker #(
        .MAX_FRAME(FRAME_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_func_code    (o_func_code),
        .o_reply_kind   (o_reply_kind),
        .o_frame_length (o_frame_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The data bits are fed least significant first, as on the serial line.
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic report_frame();
        t_result     r;
        logic [15:0] sent_crc;
        sent_crc    = {tail_bytes[7:0], tail_bytes[15:8]};
        r.func_code = second_byte;
        r.length    = frame_bytes;
        r.kind      = RK_NONE;
        if (frame_bytes <= MIN_LEN) begin
            r.status = ST_TOO_SHORT;
        end else if (crc_run != sent_crc) begin
            r.status = ST_CRC_ERROR;
        end else if (first_byte != shadow_cfg.device_address) begin
            r.status = ST_OTHER_ADDR;
        end else begin
            r.status = ST_ACCEPTED;
            if (second_byte == shadow_cfg.sensor_function) begin
                r.kind = RK_SENSOR;
            end else if (second_byte == shadow_cfg.louver_function) begin
                r.kind = RK_LOUVER;
            end else begin
                r.kind = RK_INVALID;
            end
        end
        report_q.push_back(r);
        frame_open  = 1'b0;
        quiet_ticks = 8'd0;
    endtask

    task automatic track_rx_word(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_TICK) begin
            if (frame_open) begin
                if (quiet_ticks != IDLE_MAX) begin
                    quiet_ticks++;
                end
                if (quiet_ticks >= shadow_cfg.silence_ticks) begin
                    report_frame();
                end
            end
        end else begin
            if (!frame_open) begin
                frame_open  = 1'b1;
                crc_run     = CRC_INIT;
                tail_bytes  = 16'h0000;
                frame_bytes = 9'd0;
                first_byte  = 8'h00;
                second_byte = 8'h00;
            end
            if (frame_bytes >= 2) begin
                crc_run = crc16_byte(crc_run, tail_bytes[15:8]);
            end
            tail_bytes = {tail_bytes[7:0], b};
            if (frame_bytes == 0) begin
                first_byte = b;
            end else if (frame_bytes == 1) begin
                second_byte = b;
            end
            frame_bytes++;
            quiet_ticks = 8'd0;
            if (frame_bytes >= FRAME_CAP) begin
                report_frame();
            end
        end
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shadow_cfg  = '{RST_DEVICE_ADDRESS, RST_SILENCE_TICKS,
                            RST_SENSOR_FUNCTION, RST_LOUVER_FUNCTION};
            crc_run     = CRC_INIT;
            tail_bytes  = 16'h0000;
            frame_bytes = 9'd0;
            quiet_ticks = 8'd0;
            frame_open  = 1'b0;
            first_byte  = 8'h00;
            second_byte = 8'h00;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_DEVICE_ADDRESS:  shadow_cfg.device_address  = i_cfg_wr_data;
                    REG_SILENCE_TICKS:   shadow_cfg.silence_ticks   = i_cfg_wr_data;
                    REG_SENSOR_FUNCTION: shadow_cfg.sensor_function = i_cfg_wr_data;
                    REG_LOUVER_FUNCTION: shadow_cfg.louver_function = i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                track_rx_word(i_command, i_data_byte);
            end
            if (o_valid && !i_stall) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result with none expected: expected none, got %0d %0d %0d %0d",
                             $time, o_frame_status, o_func_code, o_reply_kind,
                             o_frame_length);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    if (o_frame_status !== want.status) begin
                        flag_field("frame_status", want.status, o_frame_status);
                    end
                    if (o_func_code !== want.func_code) begin
                        flag_field("func_code", want.func_code, o_func_code);
                    end
                    if (o_reply_kind !== want.kind) begin
                        flag_field("reply_kind", want.kind, o_reply_kind);
                    end
                    if (o_frame_length !== want.length) begin
                        flag_field("frame_length", want.length, o_frame_length);
                    end
                end
            end
        end
        in_fire <= i_rst_n && i_valid && !o_stall;
    end

    // Sender: a word is held until taken; idle bursts fall only between words.
    always @(negedge i_clk) begin
        t_rx_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (!i_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 2);
                i_valid <= 1'b0;
            end else if (rx_word_q.size() > 0) begin
                nxt = rx_word_q.pop_front();
                i_valid     <= 1'b1;
                i_command   <= nxt.cmd;
                i_data_byte <= nxt.data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls, and a long hold-off whenever one is asked for.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_seen != hold_asked) begin
            hold_seen  = hold_asked;
            stall_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_word(input logic cmd, input logic [7:0] data, input bit counted);
        t_rx_word w;
        w.cmd  = cmd;
        w.data = data;
        rx_word_q.push_back(w);
        if (counted) begin
            words_queued++;
        end
    endtask

    function automatic int close_ticks();
        return (stim_sil == 0) ? 1 : int'(stim_sil);
    endfunction

    // Ticks may fall between bytes, never enough of them to end the frame early.
    task automatic push_frame(input int len, input logic [7:0] addr, input logic [7:0] func,
                              input bit good, input int ticks);
        logic [7:0]  body[$];
        logic [15:0] crc;
        body.push_back(addr);
        if (len > 1) begin
            body.push_back(func);
        end
        while (body.size() < len - 2) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        if (len >= 3) begin
            crc = CRC_INIT;
            foreach (body[i]) begin
                crc = crc16_byte(crc, body[i]);
            end
            if (!good) begin
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            end
            body.push_back(crc[7:0]);
            body.push_back(crc[15:8]);
        end
        foreach (body[i]) begin
            push_word(CMD_BYTE, body[i], 1'b1);
            if (i < body.size() - 1 && stim_sil > 1 && stim_sil <= 20
                    && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, stim_sil - 1)) begin
                    push_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end
        repeat (ticks) begin
            push_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic random_frame();
        int         pick;
        int         len;
        logic [7:0] f;
        pick = $urandom_range(0, 19);
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 60) : $urandom_range(7, 16);
        case ($urandom_range(0, 3))
            0: f = stim_sens;
            1: f = stim_louv;
            default: f = 8'($urandom_range(0, 255));
        endcase
        if (pick < 13) begin
            push_frame(len, stim_addr, f, 1'b1, close_ticks());
        end else if (pick < 15) begin
            push_frame(len, stim_addr ^ (8'h01 << $urandom_range(0, 7)), f, 1'b1,
                       close_ticks());
        end else if (pick < 17) begin
            push_frame(len, stim_addr, f, 1'b0, close_ticks());
        end else if (pick < 18) begin
            push_frame($urandom_range(1, 6), stim_addr, f, 1'b1, close_ticks());
        end else if (pick < 19) begin
            push_frame($urandom_range(1, 12), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, close_ticks());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                push_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEVICE_ADDRESS:  stim_addr = val;
            REG_SILENCE_TICKS:   stim_sil  = val;
            REG_SENSOR_FUNCTION: stim_sens = val;
            REG_LOUVER_FUNCTION: stim_louv = val;
            default: ;
        endcase
    endtask

    // Waits until every queued word has been taken and every frame report has arrived.
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (rx_word_q.size() != 0 || i_valid || report_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int         phase_no;
        int         start;
        logic [7:0] s;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register values straight out of reset.
        push_word(CMD_TICK, 8'hFF, 1'b0);
        push_frame(8, RST_DEVICE_ADDRESS, RST_SENSOR_FUNCTION, 1'b1, close_ticks());
        push_frame(9, RST_DEVICE_ADDRESS, RST_LOUVER_FUNCTION, 1'b1, close_ticks());
        drain();

        set_reg(REG_SILENCE_TICKS, 8'd1);
        set_reg(REG_UNMAPPED, 8'hAA);
        set_reg(REG_DEVICE_ADDRESS, 8'h00);
        set_reg(REG_SENSOR_FUNCTION, 8'hFF);
        set_reg(REG_LOUVER_FUNCTION, 8'hFF);
        push_word(CMD_TICK, 8'h00, 1'b0);
        push_frame(8, 8'h00, 8'hFF, 1'b1, close_ticks());
        push_frame(8, 8'hFF, 8'hFF, 1'b1, close_ticks());
        push_frame(7, 8'h00, 8'h00, 1'b1, close_ticks());
        push_frame(7, 8'h00, 8'h5A, 1'b0, close_ticks());
        push_frame(6, 8'h00, 8'hFF, 1'b1, close_ticks());
        push_frame(1, 8'h00, 8'h00, 1'b1, close_ticks());
        push_frame(2, 8'hFF, 8'h00, 1'b1, close_ticks());
        drain();

        set_reg(REG_DEVICE_ADDRESS, 8'hFF);
        set_reg(REG_SENSOR_FUNCTION, 8'h80);
        set_reg(REG_LOUVER_FUNCTION, 8'h00);
        set_reg(REG_SILENCE_TICKS, 8'd0);
        push_frame(8, 8'hFF, 8'h80, 1'b1, close_ticks());
        push_frame(8, 8'hFF, 8'h00, 1'b1, close_ticks());
        push_frame(7, 8'hFF, 8'h01, 1'b1, close_ticks());
        push_frame(7, 8'h7F, 8'h80, 1'b1, close_ticks());
        drain();

        // Registers rewritten while a frame is still open.
        set_reg(REG_DEVICE_ADDRESS, 8'h42);
        set_reg(REG_SENSOR_FUNCTION, 8'h20);
        set_reg(REG_LOUVER_FUNCTION, 8'h21);
        set_reg(REG_SILENCE_TICKS, 8'd12);
        push_frame(10, 8'h42, 8'h21, 1'b1, close_ticks());
        push_frame(9, 8'h42, 8'h20, 1'b1, 8);
        drain();
        set_reg(REG_DEVICE_ADDRESS, 8'h43);
        set_reg(REG_SILENCE_TICKS, 8'd5);
        push_word(CMD_TICK, 8'h3C, 1'b1);
        drain();

        // A frame that reaches the buffer limit closes without any tick.
        set_reg(REG_SILENCE_TICKS, 8'd1);
        push_frame(FRAME_CAP, 8'h43, 8'h20, 1'b1, 0);
        push_frame(1, 8'hC3, 8'h00, 1'b1, close_ticks());
        drain();

        // The receiver holds off while short frames keep arriving.
        set_reg(REG_SILENCE_TICKS, 8'd1);
        set_reg(REG_DEVICE_ADDRESS, 8'h5A);
        set_reg(REG_SENSOR_FUNCTION, 8'h03);
        set_reg(REG_LOUVER_FUNCTION, 8'h04);
        hold_asked++;
        repeat (12) begin
            push_frame(7, stim_addr, 8'($urandom_range(2, 5)), 1'b1, close_ticks());
        end
        drain();

        words_queued = 0;
        phase_no     = 0;
        while (words_queued < RANDOM_WORDS) begin
            phase_no++;
            calm = (phase_no % 4 == 0) || (RANDOM_WORDS - words_queued <= PHASE_WORDS);
            set_reg(REG_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
            set_reg(REG_SILENCE_TICKS, 8'($urandom_range(0, 6)));
            s = 8'($urandom_range(0, 255));
            set_reg(REG_SENSOR_FUNCTION, s);
            set_reg(REG_LOUVER_FUNCTION,
                    ($urandom_range(0, 3) == 0) ? s : 8'($urandom_range(0, 255)));
            start = words_queued;
            while (words_queued - start < PHASE_WORDS && words_queued < RANDOM_WORDS) begin
                random_frame();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** modbus_rtu_frame_checker: PASSED **");
        end else begin
            $display("** modbus_rtu_frame_checker: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** modbus_rtu_frame_checker: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_cfg.sv
hw/rtl/mrtu_frame.sv
hw/rtl/modbus_rtu_frame_checker.sv
test/tb_modbus_rtu_frame_checker.sv
